### rtl/dgcc_pkg.sv
package dgcc_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    // fixed field widths at the ports
    localparam int CMD_W   = 2;
    localparam int FIELD_W = 4;
    localparam int CFG_W   = 5;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_ADD   = 2'd1;
    localparam t_cmd CMD_CHECK = 2'd2;

    localparam logic [CFG_W-1:0] NODES_RESET = CFG_W'(16);

    typedef logic [MAX_NODES-1:0] t_node_mask;

endpackage

### rtl/directed_graph_cycle_check_unit.sv
// Directed graph cycle checker.
// Input channel (i_in_valid / o_in_stall) carries cmd, from_node, to_node.
// Output channel (o_out_valid / i_out_stall) carries cycle_found, one result
// per check command only; clear, add edge and the unused code give none.
// Clear and add edge complete in the idle state. A check walks the graph depth
// first, testing one adjacency bit per cycle in the shared neighbour-scan
// step: each node in use has its row of n bits (n the effective node
// count) scanned and is then popped, and each root is tried in turn in
// the root loop by the sequencer. The walk stops early once a cycle
// is seen. o_in_stall is high for the whole walk.
// The result sits in an output register; a stall by the receiver holds it,
// and a new item may be taken meanwhile. Should a later check finish while
// the previous result still waits, the block holds its own result until
// the register frees. i_cfg_we writes nodes_in_use (effective count is
// saturated at MAX_NODES); write it only while idle.
// Reset (synchronous, active low) empties the graph, sets nodes_in_use to
// 16, drops any pending result and returns the sequencer to idle.
module directed_graph_cycle_check_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  dgcc_pkg::t_cmd              i_cmd,
    input  logic [dgcc_pkg::FIELD_W-1:0] i_from_node,
    input  logic [dgcc_pkg::FIELD_W-1:0] i_to_node,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_cycle_found,
    input  logic                        i_cfg_we,
    input  logic [dgcc_pkg::CFG_W-1:0]  i_cfg_data
);
    import dgcc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROOT = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]             r_state;
    logic [CFG_W-1:0]       r_nodes;
    t_node_mask             r_adj [MAX_NODES];
    t_node_mask             r_visited;
    t_node_mask             r_on_path;
    logic [NODE_W-1:0]      r_stk_node [MAX_NODES];
    logic [CNT_W-1:0]       r_stk_next [MAX_NODES];
    logic [CNT_W-1:0]       r_depth;
    logic [CNT_W-1:0]       r_root;
    logic                   r_res;
    logic                   r_out_valid;
    logic                   r_cycle;

    logic [CNT_W-1:0]       n_eff;
    logic                   in_xfer;
    logic [NODE_W-1:0]      top;
    logic [NODE_W-1:0]      u;
    logic [CNT_W-1:0]       cur;
    logic [NODE_W-1:0]      v;
    logic                   edge_hit;
    logic                   out_free;

    assign n_eff = (CNT_W'(r_nodes) > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                         : CNT_W'(r_nodes);
    assign o_in_stall    = (r_state != ST_IDLE);
    assign in_xfer       = i_in_valid && !o_in_stall;
    assign top           = NODE_W'(r_depth - CNT_W'(1));
    assign u             = r_stk_node[top];
    assign cur           = r_stk_next[top];
    assign v             = cur[NODE_W-1:0];
    // shared scan step: one adjacency bit per cycle
    assign edge_hit      = (cur < n_eff) && r_adj[u][v];
    assign out_free      = !r_out_valid || !i_out_stall;
    assign o_out_valid   = r_out_valid;
    assign o_cycle_found = r_cycle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nodes     <= NODES_RESET;
            r_visited   <= '0;
            r_on_path   <= '0;
            r_depth     <= '0;
            r_root      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_NODES; i++) begin
                r_adj[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_nodes <= i_cfg_data;
            end
            // in ST_DONE the completion arm below owns the valid flag
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        unique case (i_cmd)
                            CMD_CLEAR: begin
                                for (int i = 0; i < MAX_NODES; i++) begin
                                    r_adj[i] <= '0;
                                end
                            end
                            CMD_ADD: begin
                                if ((CNT_W'(i_from_node) < n_eff) &&
                                    (CNT_W'(i_to_node) < n_eff)) begin
                                    r_adj[NODE_W'(i_from_node)][NODE_W'(i_to_node)] <= 1'b1;
                                end
                            end
                            CMD_CHECK: begin
                                r_visited <= '0;
                                r_on_path <= '0;
                                r_depth   <= '0;
                                r_root    <= '0;
                                r_state   <= ST_ROOT;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ROOT: begin
                    if (r_root >= n_eff) begin
                        r_res   <= 1'b0;
                        r_state <= ST_DONE;
                    end else if (r_visited[r_root[NODE_W-1:0]]) begin
                        r_root <= r_root + CNT_W'(1);
                    end else begin
                        r_stk_node[0] <= r_root[NODE_W-1:0];
                        r_stk_next[0] <= '0;
                        r_depth       <= CNT_W'(1);
                        r_visited[r_root[NODE_W-1:0]] <= 1'b1;
                        r_on_path[r_root[NODE_W-1:0]] <= 1'b1;
                        r_state       <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (cur >= n_eff) begin
                        // row exhausted: pop, back to the root loop when empty
                        r_on_path[u] <= 1'b0;
                        r_depth      <= r_depth - CNT_W'(1);
                        if (r_depth == CNT_W'(1)) begin
                            r_root  <= r_root + CNT_W'(1);
                            r_state <= ST_ROOT;
                        end
                    end else begin
                        r_stk_next[top] <= cur + CNT_W'(1);
                        if (edge_hit) begin
                            if (r_on_path[v]) begin
                                r_depth <= '0;
                                r_res   <= 1'b1;
                                r_state <= ST_DONE;
                            end else if (!r_visited[v]) begin
                                r_stk_node[r_depth[NODE_W-1:0]] <= v;
                                r_stk_next[r_depth[NODE_W-1:0]] <= '0;
                                r_depth      <= r_depth + CNT_W'(1);
                                r_visited[v] <= 1'b1;
                                r_on_path[v] <= 1'b1;
                            end
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_cycle     <= r_res;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CNT_W'(MAX_NODES))
        else $error("walk stack depth beyond node count");

    a_path_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_on_path & ~r_visited) == '0)
        else $error("node on path but not visited");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_depth != '0))
        else $error("scan with empty stack");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside completion");

endmodule
